// ===== sv/dmxfs_pkg.sv =====
// dmxfs_pkg: item structs, event and action codes, port phase type and
// fixed constants of the dmx512 frame scheduler
// no dependencies
package dmxfs_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] port_number;
        logic [9:0] slot_index;
        logic [7:0] slot_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_port;
        logic [1:0] action;
        logic [7:0] read_byte;
        logic [1:0] busy_mask;
        logic       last;
    } t_out_item;

    // input item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // result actions
    localparam logic [1:0] ACT_BREAK   = 2'd0;
    localparam logic [1:0] ACT_FRAME   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_DATA  = 2'd2
    } t_phase;

    localparam logic [7:0]  START_CODE    = 8'h00;
    localparam logic [15:0] REFRESH_RESET = 16'd25;

endpackage

// ===== sv/dmx512_frame_scheduler.sv =====
// dmx512_frame_scheduler: multi-port dmx512 transmit scheduler top level
// holds the working and frame slot stores; uses dmxfs_pkg and dmxfs_due_sel
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ------------------------
//   in        in         i_in_valid/o_in_stall   i_in_item  (t_in_item)
//   out       out        o_out_valid/i_out_stall o_out_item (t_out_item)
//   cfg       in         i_cfg_valid/o_cfg_ready i_cfg_data (refresh)
//
// slot write: straight into the working store; read or transmit complete: the emit step plus
// the wait for the output register; tick: a copy of each started port's slots through the
// single read port of the working store, then the emit step with one result per started port
// after reset a clearing pass zeroes both stores, one entry a cycle, all 2**(PW+SW) entries
// (1024 at the defaults); no item is taken meanwhile
// a stalled output only holds the result; the next item may still be taken
// and waits in the emit step until the output register frees up
module dmx512_frame_scheduler import dmxfs_pkg::*; #(
    parameter int PORT_COUNT = 2,
    parameter int SLOT_COUNT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int PW        = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW        = PW + SW;
    localparam int MEM_DEPTH = 2 ** AW;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_COPY  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // slot stores, addressed {port, slot}
    logic [7:0] work_mem  [MEM_DEPTH];
    logic [7:0] frame_mem [MEM_DEPTH];

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    t_phase                r_phase [PORT_COUNT];
    t_phase                n_phase [PORT_COUNT];
    logic [31:0]           r_last  [PORT_COUNT];
    logic [31:0]           n_last  [PORT_COUNT];
    logic [31:0]           r_tick, n_tick;
    logic [15:0]           r_refresh, n_refresh;
    logic [PORT_COUNT-1:0] r_copy_mask, n_copy_mask;
    logic [PORT_COUNT-1:0] r_emit_mask, n_emit_mask;
    logic [SW-1:0]         r_copy_cnt, n_copy_cnt;
    logic [1:0]            r_emit_action, n_emit_action;
    logic                  r_rd_hit, n_rd_hit;
    logic                  r_rd_start, n_rd_start;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic                  r_wr_pend, n_wr_pend;
    logic [AW-1:0]         r_wr_addr;
    logic [7:0]            r_work_rd;
    logic [7:0]            r_frame_rd;

    logic                  in_acc;
    logic                  port_ok;
    logic                  slot_ok;
    logic [PW-1:0]         in_port;
    logic [9:0]            idx_m1;
    logic [31:0]           tick_next;
    logic [PORT_COUNT-1:0] start_mask;
    logic [PORT_COUNT-1:0] busy;
    logic [PORT_COUNT+1:0] busy_ext;
    logic                  out_free;
    logic [PW-1:0]         copy_port;
    logic [PW-1:0]         emit_port;
    logic [AW-1:0]         copy_addr;
    logic [PORT_COUNT-1:0] copy_left;
    logic [PORT_COUNT-1:0] emit_left;
    logic                  work_we;
    logic [AW-1:0]         work_waddr;
    logic [7:0]            work_wdata;
    logic                  frame_we;
    logic [AW-1:0]         frame_waddr;
    logic [7:0]            frame_wdata;
    logic                  frame_re;
    logic [AW-1:0]         frame_raddr;

    function automatic logic [PW-1:0] f_lowest(input logic [PORT_COUNT-1:0] m);
        logic [PW-1:0] low;
        low = '0;
        for (int i = PORT_COUNT - 1; i >= 0; i--) begin
            if (m[i]) begin
                low = PW'(i);
            end
        end
        return low;
    endfunction

    // input decode
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign port_ok   = ({1'b0, i_in_item.port_number} < 3'(PORT_COUNT));
    assign slot_ok   = ({1'b0, i_in_item.slot_index} < 11'(SLOT_COUNT));
    assign in_port   = i_in_item.port_number[PW-1:0];
    assign idx_m1    = i_in_item.slot_index - 10'd1;
    assign tick_next = r_tick + 32'd1;
    assign out_free  = !r_out_valid || !i_out_stall;

    dmxfs_due_sel #(
        .PORT_COUNT (PORT_COUNT)
    ) u_due_sel (
        .i_tick       (tick_next),
        .i_last_start (r_last),
        .i_phase      (r_phase),
        .i_refresh    (r_refresh),
        .o_start_mask (start_mask)
    );

    always_comb begin
        for (int i = 0; i < PORT_COUNT; i++) begin
            busy[i] = (r_phase[i] != PH_IDLE);
        end
    end
    // only ports 0 and 1 show in the result field
    assign busy_ext = {2'b00, busy};

    // copy and emit walk their masks lowest port first
    assign copy_port = f_lowest(r_copy_mask);
    assign emit_port = f_lowest(r_emit_mask);
    assign copy_addr = {copy_port, r_copy_cnt};
    assign copy_left = r_copy_mask & ~(PORT_COUNT'(1) << copy_port);
    assign emit_left = r_emit_mask & ~(PORT_COUNT'(1) << emit_port);

    // store ports: clearing pass, slot writes, snapshot copy, byte reads
    assign work_we     = (r_state == S_CLEAR) ||
                         (in_acc && (i_in_item.kind == KIND_WRITE) && port_ok && slot_ok);
    assign work_waddr  = (r_state == S_CLEAR) ? r_clr_addr
                                              : {in_port, i_in_item.slot_index[SW-1:0]};
    assign work_wdata  = (r_state == S_CLEAR) ? 8'h00 : i_in_item.slot_value;
    assign frame_we    = (r_state == S_CLEAR) || r_wr_pend;
    assign frame_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
    assign frame_wdata = (r_state == S_CLEAR) ? 8'h00 : r_work_rd;
    assign frame_re    = in_acc && (i_in_item.kind == KIND_READ);
    assign frame_raddr = {in_port, idx_m1[SW-1:0]};

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            work_mem[work_waddr] <= work_wdata;
        end
        r_work_rd <= work_mem[copy_addr];
        r_wr_addr <= copy_addr;
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            r_frame_rd <= frame_mem[frame_raddr];
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_phase       = r_phase;
        n_last        = r_last;
        n_tick        = r_tick;
        n_refresh     = r_refresh;
        n_copy_mask   = r_copy_mask;
        n_emit_mask   = r_emit_mask;
        n_copy_cnt    = r_copy_cnt;
        n_emit_action = r_emit_action;
        n_rd_hit      = r_rd_hit;
        n_rd_start    = r_rd_start;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_wr_pend     = (r_state == S_COPY);

        if (i_cfg_valid) begin
            n_refresh = i_cfg_data;
        end

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.kind)
                        KIND_TICK: begin
                            n_tick = tick_next;
                            for (int i = 0; i < PORT_COUNT; i++) begin
                                if (start_mask[i]) begin
                                    n_phase[i] = PH_BREAK;
                                    n_last[i]  = tick_next;
                                end
                            end
                            if (start_mask != '0) begin
                                n_copy_mask   = start_mask;
                                n_emit_mask   = start_mask;
                                n_emit_action = ACT_BREAK;
                                n_copy_cnt    = '0;
                                n_state       = S_COPY;
                            end
                        end
                        KIND_DONE: begin
                            if (port_ok) begin
                                case (r_phase[in_port])
                                    PH_BREAK: begin
                                        n_phase[in_port] = PH_DATA;
                                        n_emit_action    = ACT_FRAME;
                                        n_emit_mask      = PORT_COUNT'(1) << in_port;
                                        n_state          = S_EMIT;
                                    end
                                    PH_DATA: begin
                                        n_phase[in_port] = PH_IDLE;
                                        n_emit_action    = ACT_RELEASE;
                                        n_emit_mask      = PORT_COUNT'(1) << in_port;
                                        n_state          = S_EMIT;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        KIND_READ: begin
                            if (port_ok) begin
                                n_emit_action = ACT_READ;
                                n_emit_mask   = PORT_COUNT'(1) << in_port;
                                n_rd_start    = (i_in_item.slot_index == 10'd0);
                                n_rd_hit      = (i_in_item.slot_index != 10'd0) &&
                                                (i_in_item.slot_index <= 10'(SLOT_COUNT));
                                n_state       = S_EMIT;
                            end
                        end
                        default: begin
                            // slot write goes straight to the working store
                        end
                    endcase
                end
            end
            S_COPY: begin
                // one working-store read per cycle, written to the frame store
                // in the next cycle
                n_copy_cnt = r_copy_cnt + SW'(1);
                if (r_copy_cnt == SW'(SLOT_COUNT - 1)) begin
                    n_copy_cnt  = '0;
                    n_copy_mask = copy_left;
                    if (copy_left == '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.out_port     = 2'(emit_port);
                    n_out.action       = r_emit_action;
                    n_out.busy_mask    = busy_ext[1:0];
                    n_out.last         = (emit_left == '0);
                    n_out.read_byte    = 8'h00;
                    if (r_emit_action == ACT_READ) begin
                        if (r_rd_hit) begin
                            n_out.read_byte = r_frame_rd;
                        end else if (r_rd_start) begin
                            n_out.read_byte = START_CODE;
                        end
                    end
                    n_emit_mask = emit_left;
                    if (emit_left == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tick      <= '0;
            r_refresh   <= REFRESH_RESET;
            r_copy_mask <= '0;
            r_emit_mask <= '0;
            r_copy_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++) begin
                r_phase[i] <= PH_IDLE;
                r_last[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_tick      <= n_tick;
            r_refresh   <= n_refresh;
            r_copy_mask <= n_copy_mask;
            r_emit_mask <= n_emit_mask;
            r_copy_cnt  <= n_copy_cnt;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
            r_phase     <= n_phase;
            r_last      <= n_last;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out         <= n_out;
        r_emit_action <= n_emit_action;
        r_rd_hit      <= n_rd_hit;
        r_rd_start    <= n_rd_start;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // ports still to copy are always among the ports still to report
    a_copy_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_copy_mask & ~r_emit_mask) == '0)
        else $error("copy mask outside emit mask");

    // a tick starts at most two frames
    a_two_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_emit_mask) <= 2)
        else $error("more than two pending results");

    // a frame-store write only trails a copy read
    a_wr_after_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(r_state == S_COPY))
        else $error("frame write without copy read");

    // a byte read gives exactly one result
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == ACT_READ)) |-> r_out.last)
        else $error("byte read result not last");

endmodule

// ===== sv/dmxfs_due_sel.sv =====
// dmxfs_due_sel: picks the ports that start a frame on a tick
// (idle, refresh period elapsed, at most the two lowest); uses dmxfs_pkg
module dmxfs_due_sel import dmxfs_pkg::*; #(
    parameter int PORT_COUNT = 2
) (
    input  logic [31:0]           i_tick,
    input  logic [31:0]           i_last_start [PORT_COUNT],
    input  t_phase                i_phase [PORT_COUNT],
    input  logic [15:0]           i_refresh,
    output logic [PORT_COUNT-1:0] o_start_mask
);

    logic [31:0]           elapsed [PORT_COUNT];
    logic [PORT_COUNT-1:0] due;
    logic [1:0]            taken;

    always_comb begin
        for (int i = 0; i < PORT_COUNT; i++) begin
            elapsed[i] = i_tick - i_last_start[i];
            due[i]     = (i_phase[i] == PH_IDLE) && (elapsed[i] >= {16'd0, i_refresh});
        end
    end

    // lowest two due ports win
    always_comb begin
        taken        = 2'd0;
        o_start_mask = '0;
        for (int i = 0; i < PORT_COUNT; i++) begin
            if (due[i] && (taken != 2'd2)) begin
                o_start_mask[i] = 1'b1;
                taken           = taken + 2'd1;
            end
        end
    end

endmodule
